/* hw/rtl/sptt_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and the table entry type of the priority task table
package sptt_pkg;

    // table geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 64;
    localparam int PRIO_W = 16;
    localparam int POS_W  = 6;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // one stored task
    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

endpackage

/* hw/rtl/sptt_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read data
module sptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data, updated only while i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

/* hw/rtl/sorted_priority_task_table.sv */
`timescale 1ns / 1ps
// top level: sequencer that keeps tasks sorted by priority in an entry ram
//
//  channel  | handshake       | payload
//  ---------+-----------------+--------------------------------------------------
//  command  | start / busy    | i_command, i_task_key, i_task_priority
//  result   | o_valid strobe  | o_status, o_result_key, o_result_priority,
//           |                 | o_position, o_last
//
// A command is taken when start is high and busy is low. Each command reads the
// entry ram once per stored entry, one read a cycle (add stops early at its
// insertion point; add to a full table is answered without going busy). List
// gives one result beat per entry as the reads return, one empty-status beat on
// an empty table. Reset clears the entry count and control state, not the ram;
// ram is never read beyond the count. Result beats last one cycle, no hold off.
module sorted_priority_task_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_command,
    input  logic [sptt_pkg::KEY_W-1:0]        i_task_key,
    input  logic signed [sptt_pkg::PRIO_W-1:0] i_task_priority,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [sptt_pkg::KEY_W-1:0]        o_result_key,
    output logic signed [sptt_pkg::PRIO_W-1:0] o_result_priority,
    output logic [sptt_pkg::POS_W-1:0]        o_position,
    output logic                              o_last
);
    import sptt_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // control state
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_left, n_left;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             r_rv, n_rv;
    logic [IDX_W-1:0] r_ridx, n_ridx;
    logic             r_found, n_found;
    logic             r_out_vld, n_out_vld;

    // command and result payload
    logic [1:0]               r_cmd, n_cmd;
    logic [KEY_W-1:0]         r_key, n_key;
    logic signed [PRIO_W-1:0] r_prio, n_prio;
    logic [1:0]               r_status, n_status;
    logic [KEY_W-1:0]         r_okey, n_okey;
    logic signed [PRIO_W-1:0] r_oprio, n_oprio;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic                     r_last, n_last;

    // ram port signals
    logic             re, we;
    logic [IDX_W-1:0] raddr, waddr;
    t_entry           wdata, rdata;

    sptt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_addr    = r_addr;
        n_rv      = 1'b0;
        n_ridx    = r_ridx;
        n_found   = r_found;
        n_out_vld = 1'b0;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_prio    = r_prio;
        n_status  = r_status;
        n_okey    = r_okey;
        n_oprio   = r_oprio;
        n_pos     = r_pos;
        n_last    = r_last;
        re        = 1'b0;
        raddr     = r_addr;
        we        = 1'b0;
        waddr     = r_ridx;
        wdata     = rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_command;
                    n_key  = i_task_key;
                    n_prio = i_task_priority;
                    if (i_command == CMD_ADD && r_cnt == CNT_W'(DEPTH)) begin
                        // full table: answer at once
                        n_out_vld = 1'b1;
                        n_status  = STAT_FULL;
                        n_okey    = i_task_key;
                        n_oprio   = i_task_priority;
                        n_pos     = '0;
                        n_last    = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                        n_found = 1'b0;
                        n_left  = r_cnt;
                        n_addr  = (i_command == CMD_ADD) ?
                                  IDX_W'(r_cnt - CNT_W'(1)) : '0;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read, downward for add, upward otherwise
                if (r_left != '0) begin
                    re     = 1'b1;
                    n_rv   = 1'b1;
                    n_ridx = r_addr;
                    n_left = r_left - CNT_W'(1);
                    n_addr = (r_cmd == CMD_ADD) ? r_addr - IDX_W'(1) :
                                                  r_addr + IDX_W'(1);
                end

                if (r_rv) begin
                    // evaluate the entry that just came back
                    unique case (r_cmd)
                        CMD_ADD: begin
                            we    = 1'b1;
                            waddr = r_ridx + IDX_W'(1);
                            if (rdata.prio >= r_prio) begin
                                wdata.key  = r_key;
                                wdata.prio = r_prio;
                                n_state    = S_IDLE;
                                n_cnt      = r_cnt + CNT_W'(1);
                                n_out_vld  = 1'b1;
                                n_status   = STAT_OK;
                                n_okey     = r_key;
                                n_oprio    = r_prio;
                                n_pos      = POS_W'(r_ridx + IDX_W'(1));
                                n_last     = 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH: begin
                            if (!r_found && rdata.key == r_key) begin
                                n_found = 1'b1;
                                n_okey  = rdata.key;
                                n_oprio = rdata.prio;
                                n_pos   = POS_W'(r_ridx);
                            end else if (r_found && r_cmd == CMD_REMOVE) begin
                                // close the gap behind the removed entry
                                we    = 1'b1;
                                waddr = r_ridx - IDX_W'(1);
                            end
                        end
                        CMD_LIST: begin
                            n_out_vld = 1'b1;
                            n_status  = STAT_OK;
                            n_okey    = rdata.key;
                            n_oprio   = rdata.prio;
                            n_pos     = POS_W'(r_ridx);
                            n_last    = (CNT_W'(r_ridx) + CNT_W'(1) == r_cnt);
                        end
                        default: ;
                    endcase
                end else if (r_left == '0) begin
                    // scan exhausted
                    n_state = S_IDLE;
                    n_last  = 1'b1;
                    unique case (r_cmd)
                        CMD_ADD: begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata.key  = r_key;
                            wdata.prio = r_prio;
                            n_cnt      = r_cnt + CNT_W'(1);
                            n_out_vld  = 1'b1;
                            n_status   = STAT_OK;
                            n_okey     = r_key;
                            n_oprio    = r_prio;
                            n_pos      = '0;
                        end
                        CMD_REMOVE, CMD_SEARCH: begin
                            n_out_vld = 1'b1;
                            if (r_found) begin
                                n_status = STAT_OK;
                                if (r_cmd == CMD_REMOVE) begin
                                    n_cnt = r_cnt - CNT_W'(1);
                                end
                            end else begin
                                n_status = STAT_NOT_FOUND;
                                n_okey   = r_key;
                                n_oprio  = '0;
                                n_pos    = '0;
                            end
                        end
                        CMD_LIST: begin
                            if (r_cnt == '0) begin
                                n_out_vld = 1'b1;
                                n_status  = STAT_EMPTY;
                                n_okey    = '0;
                                n_oprio   = '0;
                                n_pos     = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_left    <= '0;
            r_addr    <= '0;
            r_rv      <= 1'b0;
            r_ridx    <= '0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_addr    <= n_addr;
            r_rv      <= n_rv;
            r_ridx    <= n_ridx;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_prio   <= n_prio;
        r_status <= n_status;
        r_okey   <= n_okey;
        r_oprio  <= n_oprio;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    // outputs
    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_out_vld;
    assign o_status          = r_status;
    assign o_result_key      = r_okey;
    assign o_result_priority = r_oprio;
    assign o_position        = r_pos;
    assign o_last            = r_last;
endmodule

/* test/sorted_priority_task_table_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the sorted priority task table: shadow table, command driver, beat monitor
module sorted_priority_task_table_tb;
    import sptt_pkg::*;

    // one command beat and one result beat
    typedef struct {
        logic [1:0]               cmd;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } t_task_cmd;

    typedef struct {
        logic [1:0]               status;
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } t_task_report;

    // dut ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               i_command = CMD_LIST;
    logic [KEY_W-1:0]         i_task_key = '0;
    logic signed [PRIO_W-1:0] i_task_priority = '0;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic [KEY_W-1:0]         o_result_key;
    logic signed [PRIO_W-1:0] o_result_priority;
    logic [POS_W-1:0]         o_position;
    logic                     o_last;

    // bench state
    t_task_cmd                pending_cmds[$];
    t_task_report             expected_reports[$];
    logic [KEY_W-1:0]         key_pool[20];
    logic [KEY_W-1:0]         shadow_key[DEPTH];
    logic signed [PRIO_W-1:0] shadow_prio[DEPTH];
    int                       shadow_count = 0;
    int                       gap_left = 0;
    int                       error_count = 0;

    sorted_priority_task_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_task_key       (i_task_key),
        .i_task_priority  (i_task_priority),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_result_key     (o_result_key),
        .o_result_priority(o_result_priority),
        .o_position       (o_position),
        .o_last           (o_last)
    );

    // clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop
    initial begin
        #2000000;
        $display("sorted_priority_task_table test failed");
        $finish;
    end

    // shadow table: apply one accepted command and queue the beats it must produce
    function automatic void apply_to_shadow_table(t_task_cmd c);
        t_task_report r;
        int           pos;
        r.status = STAT_OK;
        r.key    = c.key;
        r.prio   = c.prio;
        r.pos    = '0;
        r.last   = 1'b1;
        case (c.cmd)
            CMD_ADD: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // insert after every entry of equal or higher priority
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] >= c.prio)
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_key[i]  = shadow_key[i-1];
                        shadow_prio[i] = shadow_prio[i-1];
                    end
                    shadow_key[pos]  = c.key;
                    shadow_prio[pos] = c.prio;
                    shadow_count++;
                    r.pos = pos[POS_W-1:0];
                end
                expected_reports.push_back(r);
            end
            CMD_REMOVE, CMD_SEARCH: begin
                // first entry holding the key
                pos = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_key[i] == c.key)
                        pos = i;
                if (pos == shadow_count) begin
                    r.status = STAT_NOT_FOUND;
                    r.prio   = '0;
                end else begin
                    r.key  = shadow_key[pos];
                    r.prio = shadow_prio[pos];
                    r.pos  = pos[POS_W-1:0];
                    if (c.cmd == CMD_REMOVE) begin
                        for (int i = pos; i + 1 < shadow_count; i++) begin
                            shadow_key[i]  = shadow_key[i+1];
                            shadow_prio[i] = shadow_prio[i+1];
                        end
                        shadow_count--;
                    end
                end
                expected_reports.push_back(r);
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                    r.key    = '0;
                    r.prio   = '0;
                    expected_reports.push_back(r);
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        r.key  = shadow_key[i];
                        r.prio = shadow_prio[i];
                        r.pos  = i[POS_W-1:0];
                        r.last = (i + 1 == shadow_count);
                        expected_reports.push_back(r);
                    end
                end
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                      logic signed [PRIO_W-1:0] prio);
        t_task_cmd c;
        c.cmd  = cmd;
        c.key  = key;
        c.prio = prio;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // mostly keys from a small pool so that remove and search find entries
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, 19)];
        return rand_key();
    endfunction

    // mix of a narrow band (many ties) and the full range
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int v;
        if ($urandom_range(0, 1) == 0) begin
            v = $urandom_range(0, 7) - 4;
            return v[PRIO_W-1:0];
        end
        return PRIO_W'($urandom_range(0, 65535));
    endfunction

    // stimulus
    initial begin
        int r;
        int add_heavy;
        key_pool[0] = '1;
        key_pool[1] = '0;
        for (int i = 2; i < 20; i++)
            key_pool[i] = rand_key();

        // empty table cases
        queue_cmd(CMD_LIST, rand_key(), pick_prio());
        queue_cmd(CMD_REMOVE, key_pool[0], pick_prio());
        queue_cmd(CMD_SEARCH, key_pool[1], pick_prio());
        // priority extremes, ties and a duplicate key
        queue_cmd(CMD_ADD, key_pool[0], 16'sh7fff);
        queue_cmd(CMD_ADD, key_pool[1], 16'sh8000);
        queue_cmd(CMD_ADD, key_pool[2], 16'sh0000);
        queue_cmd(CMD_ADD, key_pool[3], 16'sh0000);
        queue_cmd(CMD_ADD, key_pool[2], 16'shffff);
        queue_cmd(CMD_SEARCH, key_pool[2], pick_prio());
        queue_cmd(CMD_REMOVE, key_pool[2], pick_prio());
        queue_cmd(CMD_SEARCH, key_pool[5], pick_prio());
        queue_cmd(CMD_LIST, rand_key(), pick_prio());
        // fill to the top, overflow, list a full table
        for (int i = 0; i < DEPTH - 4; i++)
            queue_cmd(CMD_ADD, key_pool[4 + i], pick_prio());
        queue_cmd(CMD_ADD, rand_key(), pick_prio());
        queue_cmd(CMD_LIST, rand_key(), pick_prio());

        // random part: alternating fill-heavy and drain-heavy stretches
        for (int n = 0; n < 360; n++) begin
            add_heavy = ((n / 40) % 2 == 0);
            r = $urandom_range(0, 99);
            if (add_heavy ? (r < 65) : (r < 25))
                queue_cmd(CMD_ADD, pick_key(), pick_prio());
            else if (add_heavy ? (r < 78) : (r < 60))
                queue_cmd(CMD_REMOVE, pick_key(), pick_prio());
            else if (add_heavy ? (r < 90) : (r < 82))
                queue_cmd(CMD_SEARCH, pick_key(), pick_prio());
            else
                queue_cmd(CMD_LIST, rand_key(), pick_prio());
        end

        // drain, then let stray beats show up
        @(posedge i_rst_n);
        while (pending_cmds.size() != 0 || start || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (3 * DEPTH) @(posedge i_clk);
        if (error_count == 0)
            $display("sorted_priority_task_table test passed");
        else
            $display("sorted_priority_task_table test failed");
        $finish;
    end

    // command driver with random idle bursts, none near the end
    always @(posedge i_clk) begin : cmd_driver
        logic took;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) begin
                apply_to_shadow_table(pending_cmds[0]);
                void'(pending_cmds.pop_front());
            end
            if (start && !took) begin
                // hold the beat until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
                start <= 1'b0;
            end else if (pending_cmds.size() > 60 && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 14) - 1;
                start <= 1'b0;
            end else begin
                start           <= 1'b1;
                i_command       <= pending_cmds[0].cmd;
                i_task_key      <= pending_cmds[0].key;
                i_task_priority <= pending_cmds[0].prio;
            end
        end
    end

    function automatic void check_field(string name, logic [KEY_W-1:0] exp_v,
                                        logic [KEY_W-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            if (error_count <= 60)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name,
                         exp_v, act_v);
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin : beat_monitor
        t_task_report e;
        if (i_rst_n && o_valid) begin
            if (expected_reports.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none actual key %h",
                         $time, o_result_key);
            end else begin
                e = expected_reports.pop_front();
                check_field("status", KEY_W'(e.status), KEY_W'(o_status));
                check_field("result_key", e.key, o_result_key);
                check_field("result_priority", KEY_W'(e.prio[PRIO_W-1:0]),
                            KEY_W'(o_result_priority[PRIO_W-1:0]));
                check_field("position", KEY_W'(e.pos), KEY_W'(o_position));
                check_field("last", KEY_W'(e.last), KEY_W'(o_last));
            end
        end
    end

endmodule

/* filelist.f */
hw/rtl/sptt_pkg.sv
hw/rtl/sptt_ram.sv
hw/rtl/sorted_priority_task_table.sv
test/sorted_priority_task_table_tb.sv
